[design/crs_pkg.sv]
// Package for the clip rectangle stack: depth constants, action and status
// codes, the rectangle type and the clip and join functions.
// No dependencies.
`default_nettype none

package crs_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // Action codes
    localparam logic [1:0] ACT_PUSH      = 2'd0;
    localparam logic [1:0] ACT_POP       = 2'd1;
    localparam logic [1:0] ACT_JOIN      = 2'd2;
    localparam logic [1:0] ACT_INTERSECT = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic               set;
        logic signed [15:0] h;
        logic signed [15:0] w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } rect_t;

    // Clip dst to lim; disjoint set rectangles give an all-zero unset result
    function automatic rect_t rect_clip(input rect_t dst, input rect_t lim);
        rect_t              r;
        logic signed [15:0] dst_r;
        logic signed [15:0] dst_b;
        logic signed [15:0] lim_r;
        logic signed [15:0] lim_b;
        logic signed [15:0] new_r;
        logic signed [15:0] new_b;
        logic               overlap;
        r       = dst;
        dst_r   = dst.x + dst.w;
        dst_b   = dst.y + dst.h;
        lim_r   = lim.x + lim.w;
        lim_b   = lim.y + lim.h;
        overlap = (lim.x <= dst_r) && (lim_r >= dst.x) &&
                  (lim.y <= dst_b) && (lim_b >= dst.y);
        if (dst.set && lim.set) begin
            if (!overlap) begin
                r = '0;
            end else begin
                if (dst.x < lim.x) begin
                    r.x = lim.x;
                end
                if (dst.y < lim.y) begin
                    r.y = lim.y;
                end
                // right and bottom use the moved left and top edges
                new_r = r.x + r.w;
                new_b = r.y + r.h;
                if (new_r > lim_r) begin
                    r.w = lim_r - r.x;
                end
                if (new_b > lim_b) begin
                    r.h = lim_b - r.y;
                end
            end
        end
        return r;
    endfunction

    // Grow dst to the bounding box of dst and src
    function automatic rect_t rect_join(input rect_t dst, input rect_t src);
        rect_t              r;
        logic signed [15:0] src_r;
        logic signed [15:0] src_b;
        logic signed [15:0] new_r;
        logic signed [15:0] new_b;
        r     = dst;
        src_r = src.x + src.w;
        src_b = src.y + src.h;
        if (src.set) begin
            if (!dst.set) begin
                r = src;
            end else begin
                if (dst.x > src.x) begin
                    r.x = src.x;
                end
                if (dst.y > src.y) begin
                    r.y = src.y;
                end
                new_r = r.x + r.w;
                new_b = r.y + r.h;
                if (new_r < src_r) begin
                    r.w = src_r - r.x;
                end
                if (new_b < src_b) begin
                    r.h = src_b - r.y;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/clip_rectangle_stack_top.sv]
// Clip rectangle stack: an accepted beat is registered with the top entry and
// the one below it from the stack memories; EXEC then updates, writes back
// and loads the result. A new beat waits for IDLE and a free result register.
// Reset clears the stack pointer and the handshake state; the stack memories
// are not cleared; entries at or above the pointer never reach the result.
// Depends on crs_pkg.
`default_nettype none

module clip_rectangle_stack_top
    import crs_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire        [1:0]  s_action,
    input  wire signed [15:0] s_rect_x,
    input  wire signed [15:0] s_rect_y,
    input  wire signed [15:0] s_rect_width,
    input  wire signed [15:0] s_rect_height,
    input  wire               s_rect_set,
    output logic              m_valid,
    input  wire               m_ready,
    output logic signed [15:0] m_top_x,
    output logic signed [15:0] m_top_y,
    output logic signed [15:0] m_top_width,
    output logic signed [15:0] m_top_height,
    output logic              m_top_set,
    output logic       [4:0]  m_stack_level,
    output logic       [1:0]  m_status
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    // Stack memories
    logic [31:0] mem_corner [STACK_DEPTH];
    logic [32:0] mem_extent [STACK_DEPTH];

    logic                state_reg;
    logic                state_next;
    logic [SP_W-1:0]     sp_reg;
    logic [SP_W-1:0]     sp_next;
    logic [1:0]          act_reg;
    rect_t               op_reg;
    logic [31:0]         top_corner_reg;
    logic [32:0]         top_extent_reg;
    logic [31:0]         below_corner_reg;
    logic [32:0]         below_extent_reg;

    logic                out_valid_reg;
    rect_t               out_rect_reg;
    logic [4:0]          out_level_reg;
    logic [1:0]          out_status_reg;

    logic                accept;
    logic [SP_W-1:0]     sp_m1;
    logic [SP_W-1:0]     sp_m2;
    logic [ADDR_W-1:0]   top_idx;
    logic [ADDR_W-1:0]   below_idx;
    rect_t               top_rect;
    rect_t               below_rect;
    rect_t               new_rect;
    rect_t               res_rect;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [1:0]          status;
    logic [SP_W+4:0]     level_wide;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign sp_m1     = sp_reg - SP_W'(1);
    assign sp_m2     = sp_reg - SP_W'(2);
    assign top_idx   = sp_m1[ADDR_W-1:0];
    assign below_idx = sp_m2[ADDR_W-1:0];

    // Unpack the entries read in the accept cycle
    always_comb begin
        top_rect.x     = top_corner_reg[15:0];
        top_rect.y     = top_corner_reg[31:16];
        top_rect.w     = top_extent_reg[15:0];
        top_rect.h     = top_extent_reg[31:16];
        top_rect.set   = top_extent_reg[32];
        below_rect.x   = below_corner_reg[15:0];
        below_rect.y   = below_corner_reg[31:16];
        below_rect.w   = below_extent_reg[15:0];
        below_rect.h   = below_extent_reg[31:16];
        below_rect.set = below_extent_reg[32];
    end

    // Apply the action to the top entry
    always_comb begin
        new_rect = top_rect;
        res_rect = top_rect;
        wr_en    = 1'b0;
        wr_addr  = top_idx;
        sp_next  = sp_reg;
        status   = STAT_OK;
        unique case (act_reg)
            ACT_PUSH: begin
                if (sp_reg == SP_FULL) begin
                    status = STAT_FULL;
                end else begin
                    new_rect = (sp_reg != '0) ? rect_clip(op_reg, top_rect) : op_reg;
                    res_rect = new_rect;
                    wr_en    = 1'b1;
                    wr_addr  = sp_reg[ADDR_W-1:0];
                    sp_next  = sp_reg + SP_W'(1);
                end
            end
            ACT_POP: begin
                if (sp_reg == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    res_rect = below_rect;
                    sp_next  = sp_m1;
                end
            end
            ACT_JOIN: begin
                if (sp_reg == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    new_rect = rect_join(top_rect, op_reg);
                    res_rect = new_rect;
                    wr_en    = 1'b1;
                end
            end
            ACT_INTERSECT: begin
                if (sp_reg == '0) begin
                    status = STAT_EMPTY;
                end else begin
                    new_rect = rect_clip(top_rect, op_reg);
                    res_rect = new_rect;
                    wr_en    = 1'b1;
                end
            end
            default: begin
                status = STAT_OK;
            end
        endcase
    end

    assign level_wide = {5'd0, sp_next};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC) begin
                sp_reg        <= sp_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the input beat and read the top two entries
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg          <= s_action;
            op_reg.x         <= s_rect_x;
            op_reg.y         <= s_rect_y;
            op_reg.w         <= s_rect_width;
            op_reg.h         <= s_rect_height;
            op_reg.set       <= s_rect_set;
            top_corner_reg   <= mem_corner[top_idx];
            top_extent_reg   <= mem_extent[top_idx];
            below_corner_reg <= mem_corner[below_idx];
            below_extent_reg <= mem_extent[below_idx];
        end
    end

    // Write back the updated entry
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_EXEC) && wr_en) begin
            mem_corner[wr_addr] <= {new_rect.y, new_rect.x};
            mem_extent[wr_addr] <= {new_rect.set, new_rect.h, new_rect.w};
        end
    end

    // Load the result register; an absent or unset top reads as zero
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EXEC) begin
            out_rect_reg   <= ((sp_next != '0) && res_rect.set) ? res_rect : '0;
            out_level_reg  <= level_wide[4:0];
            out_status_reg <= status;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_top_x       = out_rect_reg.x;
    assign m_top_y       = out_rect_reg.y;
    assign m_top_width   = out_rect_reg.w;
    assign m_top_height  = out_rect_reg.h;
    assign m_top_set     = out_rect_reg.set;
    assign m_stack_level = out_level_reg;
    assign m_status      = out_status_reg;

endmodule

`default_nettype wire
